// ----- rtl/sbce_pkg.sv -----
// ----------------------------------------------------------------------------
// sbce_pkg: shared types and constants for the sketch count estimator
// Request/response payloads, register map, and the command and response structs
// of the shared divider and multiplier.
// ----------------------------------------------------------------------------
package sbce_pkg;

   localparam int FRAC_BITS_DEFAULT = 24;

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   localparam logic [2:0] REG_PRIOR_MEAN   = 3'd0;
   localparam logic [2:0] REG_INV_PRIOR_WT = 3'd1;
   localparam logic [2:0] REG_ROW_COUNT    = 3'd2;
   localparam logic [2:0] REG_ROW_WIDTH    = 3'd3;
   localparam logic [2:0] REG_STREAM_TOTAL = 3'd4;

   localparam logic [4:0]  ROW_COUNT_RESET = 5'd4;
   localparam logic [20:0] ROW_WIDTH_RESET = 21'd65536;

   localparam int DIV_NUM_W = 128;
   localparam int DIV_DEN_W = 64;
   localparam int DIV_CNT_W = 8;
   localparam int MUL_OP_W  = 64;
   localparam int MUL_RES_W = 128;

   typedef struct packed {
      logic [31:0] counter_volume;
      logic [20:0] counter_card;
      logic        last_pair;
   } req_type;

   typedef struct packed {
      logic signed [63:0] estimate;
      logic               status;
   } rsp_type;

   typedef struct packed {
      logic signed [47:0] prior_mean;
      logic [47:0]        inv_prior_weight;
      logic [4:0]         row_count;
      logic [20:0]        row_width;
      logic [39:0]        stream_total;
   } cfg_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_CNT_W-1:0] steps;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic                start;
      logic [MUL_OP_W-1:0] a;
      logic [MUL_OP_W-1:0] b;
   } mul_cmd_type;

   typedef struct packed {
      logic                 done;
      logic [MUL_RES_W-1:0] product;
   } mul_rsp_type;

endpackage

// ----- rtl/sbce_csr.sv -----
// ----------------------------------------------------------------------------
// sbce_csr: configuration register file
// APB-style slave holding the prior and sketch geometry registers.
// ----------------------------------------------------------------------------
module sbce_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [sbce_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [sbce_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [sbce_pkg::CSR_DATA_W-1:0]      prdata,
   output sbce_pkg::cfg_type                    cfg
);

   sbce_pkg::cfg_type cfg_ff;
   logic              wr_en;
   logic [2:0]        reg_sel;

   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = paddr[5:3];
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prior_mean       <= '0;
         cfg_ff.inv_prior_weight <= '0;
         cfg_ff.row_count        <= sbce_pkg::ROW_COUNT_RESET;
         cfg_ff.row_width        <= sbce_pkg::ROW_WIDTH_RESET;
         cfg_ff.stream_total     <= '0;
      end else if (wr_en) begin
         case (reg_sel)
            sbce_pkg::REG_PRIOR_MEAN:   cfg_ff.prior_mean       <= pwdata[47:0];
            sbce_pkg::REG_INV_PRIOR_WT: cfg_ff.inv_prior_weight <= pwdata[47:0];
            sbce_pkg::REG_ROW_COUNT:    cfg_ff.row_count        <= pwdata[4:0];
            sbce_pkg::REG_ROW_WIDTH:    cfg_ff.row_width        <= pwdata[20:0];
            sbce_pkg::REG_STREAM_TOTAL: cfg_ff.stream_total     <= pwdata[39:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         sbce_pkg::REG_PRIOR_MEAN:   prdata = {16'd0, cfg_ff.prior_mean};
         sbce_pkg::REG_INV_PRIOR_WT: prdata = {16'd0, cfg_ff.inv_prior_weight};
         sbce_pkg::REG_ROW_COUNT:    prdata = {59'd0, cfg_ff.row_count};
         sbce_pkg::REG_ROW_WIDTH:    prdata = {43'd0, cfg_ff.row_width};
         sbce_pkg::REG_STREAM_TOTAL: prdata = {24'd0, cfg_ff.stream_total};
         default:                    prdata = '0;
      endcase
   end

endmodule

// ----- rtl/sbce_div.sv -----
// ----------------------------------------------------------------------------
// sbce_div: shared restoring divider
// One quotient bit per cycle; the dividend is aligned to the top of the shift
// register and the quotient collects in its low bits after the step count.
// ----------------------------------------------------------------------------
module sbce_div (
   input  logic                  clock,
   input  logic                  reset,
   input  sbce_pkg::div_cmd_type cmd,
   output sbce_pkg::div_rsp_type rsp
);

   logic                           run_ff;
   logic                           done_ff;
   logic [sbce_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic [sbce_pkg::DIV_NUM_W-1:0] num_ff;
   logic [sbce_pkg::DIV_DEN_W-1:0] rem_ff;
   logic [sbce_pkg::DIV_DEN_W-1:0] den_ff;

   logic [sbce_pkg::DIV_DEN_W:0]   cand;
   logic [sbce_pkg::DIV_DEN_W+1:0] diff;
   logic                           fits;
   logic [sbce_pkg::DIV_DEN_W-1:0] rem_in;

   assign cand   = {rem_ff, num_ff[sbce_pkg::DIV_NUM_W-1]};
   assign diff   = {1'b0, cand} - {2'b00, den_ff};
   assign fits   = ~diff[sbce_pkg::DIV_DEN_W+1];
   assign rem_in = fits ? diff[sbce_pkg::DIV_DEN_W-1:0] : cand[sbce_pkg::DIV_DEN_W-1:0];

   assign rsp.done     = done_ff;
   assign rsp.quotient = num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            run_ff <= 1'b1;
            cnt_ff <= cmd.steps;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == sbce_pkg::DIV_CNT_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         num_ff <= cmd.dividend;
         den_ff <= cmd.divisor;
         rem_ff <= '0;
      end else if (run_ff) begin
         num_ff <= {num_ff[sbce_pkg::DIV_NUM_W-2:0], fits};
         rem_ff <= rem_in;
      end
   end

endmodule

// ----- rtl/sbce_mul.sv -----
// ----------------------------------------------------------------------------
// sbce_mul: shared 64x64 multiplier
// Four 32x32 partial products through one registered multiplier, summed into
// a 128-bit accumulator in the cycle after each product is registered.
// ----------------------------------------------------------------------------
module sbce_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  sbce_pkg::mul_cmd_type cmd,
   output sbce_pkg::mul_rsp_type rsp
);

   logic                           run_ff;
   logic                           done_ff;
   logic                           pv_ff;
   logic [2:0]                     phase_ff;
   logic [sbce_pkg::MUL_OP_W-1:0]  a_ff;
   logic [sbce_pkg::MUL_OP_W-1:0]  b_ff;
   logic [63:0]                    prod_ff;
   logic [1:0]                     sh_ff;
   logic [sbce_pkg::MUL_RES_W-1:0] acc_ff;

   logic                           a_hi;
   logic                           b_hi;
   logic [31:0]                    a_half;
   logic [31:0]                    b_half;
   logic [sbce_pkg::MUL_RES_W-1:0] prod_sh;

   assign a_hi   = phase_ff[0];
   assign b_hi   = phase_ff[1];
   assign a_half = a_hi ? a_ff[63:32] : a_ff[31:0];
   assign b_half = b_hi ? b_ff[63:32] : b_ff[31:0];

   always_comb begin
      case (sh_ff)
         2'd0:    prod_sh = {64'd0, prod_ff};
         2'd1:    prod_sh = {32'd0, prod_ff, 32'd0};
         2'd2:    prod_sh = {prod_ff, 64'd0};
         default: prod_sh = '0;
      endcase
   end

   assign rsp.done    = done_ff;
   assign rsp.product = acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         pv_ff    <= 1'b0;
         phase_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            run_ff   <= 1'b1;
            pv_ff    <= 1'b0;
            phase_ff <= '0;
         end else if (run_ff) begin
            if (phase_ff == 3'd4) begin
               run_ff  <= 1'b0;
               pv_ff   <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               pv_ff    <= 1'b1;
               phase_ff <= phase_ff + 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         a_ff   <= cmd.a;
         b_ff   <= cmd.b;
         acc_ff <= '0;
      end else begin
         if (run_ff && phase_ff != 3'd4) begin
            prod_ff <= a_half * b_half;
            sh_ff   <= {1'b0, a_hi} + {1'b0, b_hi};
         end
         if (pv_ff) begin
            acc_ff <= acc_ff + prod_sh;
         end
      end
   end

endmodule

// ----- rtl/sketch_bayes_count_estimator.sv -----
// ----------------------------------------------------------------------------
// sketch_bayes_count_estimator: posterior count estimate from sketch counters
// Sequencer around one shared divider and one shared multiplier.
// ----------------------------------------------------------------------------
// A query is a run of counter pairs, one per request, taken when start is
// high and busy is low. Each pair is divided twice on the shared radix-2
// divider (32+FRAC_BITS and 21+FRAC_BITS quotient bits), and the next
// request can be taken as soon as busy drops; a pair with cardinality one
// skips both divides. The pair marked last adds three 64x64 products on the
// shared multiplier and a 128-bit divide; a zero denominator skips both.
// The estimate appears on rsp_data for exactly one cycle with rsp_valid
// high; the receiver cannot stall it, so it must take the response in that
// cycle. Registers must be written only while busy is low; the block itself
// does not enforce it.
module sketch_bayes_count_estimator #(
   parameter int FRAC_BITS = sbce_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  sbce_pkg::req_type               req_data,
   output logic                            rsp_valid,
   output sbce_pkg::rsp_type               rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [sbce_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [sbce_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [sbce_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

   localparam int SHIFT_IPW = 32 - FRAC_BITS;
   localparam int SHIFT_T1  = 48 - FRAC_BITS;
   localparam logic [sbce_pkg::DIV_CNT_W-1:0] STEPS_VOL  =
      sbce_pkg::DIV_CNT_W'(32 + FRAC_BITS);
   localparam logic [sbce_pkg::DIV_CNT_W-1:0] STEPS_CARD =
      sbce_pkg::DIV_CNT_W'(21 + FRAC_BITS);
   localparam logic [sbce_pkg::DIV_CNT_W-1:0] STEPS_FINAL =
      sbce_pkg::DIV_CNT_W'(sbce_pkg::DIV_NUM_W);

   localparam logic [63:0] INT_MAX = {1'b0, {63{1'b1}}};
   localparam logic [63:0] INT_MIN = {1'b1, 63'd0};

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_PAIR      = 4'd1;
   localparam logic [3:0] S_DIVV_GO   = 4'd2;
   localparam logic [3:0] S_DIVV_WAIT = 4'd3;
   localparam logic [3:0] S_DIVC_GO   = 4'd4;
   localparam logic [3:0] S_DIVC_WAIT = 4'd5;
   localparam logic [3:0] S_FIN       = 4'd6;
   localparam logic [3:0] S_MUL1_GO   = 4'd7;
   localparam logic [3:0] S_MUL1_WAIT = 4'd8;
   localparam logic [3:0] S_MUL2_GO   = 4'd9;
   localparam logic [3:0] S_MUL2_WAIT = 4'd10;
   localparam logic [3:0] S_MUL3_GO   = 4'd11;
   localparam logic [3:0] S_MUL3_WAIT = 4'd12;
   localparam logic [3:0] S_DIVF_GO   = 4'd13;
   localparam logic [3:0] S_DIVF_WAIT = 4'd14;

   function automatic logic [63:0] from_mag(input logic neg, input logic [63:0] mag);
      logic [63:0] res;
      if (!neg) begin
         res = mag[63] ? INT_MAX : mag;
      end else if (mag[63]) begin
         res = INT_MIN;
      end else begin
         res = (~mag) + 64'd1;
      end
      return res;
   endfunction

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      logic [63:0] res;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         res = s[64] ? INT_MIN : INT_MAX;
      end else begin
         res = s[63:0];
      end
      return res;
   endfunction

   sbce_pkg::cfg_type     cfg;
   sbce_pkg::div_cmd_type div_cmd;
   sbce_pkg::div_rsp_type div_rsp;
   sbce_pkg::mul_cmd_type mul_cmd;
   sbce_pkg::mul_rsp_type mul_rsp;

   logic [3:0]   state_ff;
   logic [31:0]  vol_ff;
   logic [20:0]  card_ff;
   logic         last_ff;
   logic [63:0]  vrs_ff;
   logic [63:0]  crs_ff;
   logic         err_ff;
   logic [63:0]  den_ff;
   logic [127:0] acc_ff;
   logic         nneg_ff;
   logic         rsp_valid_ff;
   sbce_pkg::rsp_type rsp_data_ff;

   // per-pair operands
   logic         dneg;
   logic [20:0]  dmag;
   logic [21:0]  cn;
   logic         cn_neg;
   logic [20:0]  cn_mag;
   logic [63:0]  pair_q;
   logic [63:0]  r1;
   logic [63:0]  r2;

   // final operands
   logic [47:0]  ipw_sh;
   logic [63:0]  den_c;
   logic         mu_neg;
   logic [47:0]  mu_mag;
   logic         wm1_neg;
   logic [20:0]  wm1_mag;
   logic [63:0]  vrs_mag;
   logic         t3_neg;
   logic [127:0] t1_mag;
   logic [63:0]  den_mag;
   logic [127:0] num;
   logic [127:0] num_mag;
   logic         est_neg;
   logic [63:0]  est_c;

   sbce_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   sbce_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   sbce_mul u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd),
      .rsp   (mul_rsp)
   );

   assign pready    = 1'b1;
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // cardinality zero divides by minus one
   assign dneg   = (card_ff == 21'd0);
   assign dmag   = dneg ? 21'd1 : (card_ff - 21'd1);
   assign cn     = {1'b0, cfg.row_width} - {1'b0, card_ff};
   assign cn_neg = cn[21];
   assign cn_mag = cn_neg ? 21'((~cn) + 22'd1) : cn[20:0];
   assign pair_q = div_rsp.quotient[63:0];
   assign r1     = from_mag(dneg, pair_q);
   assign r2     = from_mag(dneg != cn_neg, pair_q);

   assign ipw_sh  = cfg.inv_prior_weight >> SHIFT_IPW;
   assign den_c   = sat_add({16'd0, ipw_sh}, crs_ff);
   assign mu_neg  = cfg.prior_mean[47];
   assign mu_mag  = mu_neg ? ((~cfg.prior_mean) + 48'd1) : cfg.prior_mean;
   assign wm1_neg = (cfg.row_width == 21'd0);
   assign wm1_mag = wm1_neg ? 21'd1 : (cfg.row_width - 21'd1);
   assign vrs_mag = vrs_ff[63] ? ((~vrs_ff) + 64'd1) : vrs_ff;
   assign t3_neg  = wm1_neg != vrs_ff[63];
   assign t1_mag  = mul_rsp.product >> SHIFT_T1;
   assign den_mag = den_ff[63] ? ((~den_ff) + 64'd1) : den_ff;
   assign num     = acc_ff << FRAC_BITS;
   assign num_mag = num[127] ? ((~num) + 128'd1) : num;
   assign est_neg = nneg_ff != den_ff[63];
   assign est_c   = (div_rsp.quotient[127:64] != 64'd0) ?
                    (est_neg ? INT_MIN : INT_MAX) :
                    from_mag(est_neg, div_rsp.quotient[63:0]);

   always_comb begin
      div_cmd = '0;
      case (state_ff)
         S_DIVV_GO: begin
            div_cmd.start    = 1'b1;
            div_cmd.steps    = STEPS_VOL;
            div_cmd.dividend = {vol_ff, 96'd0};
            div_cmd.divisor  = {43'd0, dmag};
         end
         S_DIVC_GO: begin
            div_cmd.start    = 1'b1;
            div_cmd.steps    = STEPS_CARD;
            div_cmd.dividend = {cn_mag, 107'd0};
            div_cmd.divisor  = {43'd0, dmag};
         end
         S_DIVF_GO: begin
            div_cmd.start    = 1'b1;
            div_cmd.steps    = STEPS_FINAL;
            div_cmd.dividend = num_mag;
            div_cmd.divisor  = den_mag;
         end
         default: ;
      endcase
   end

   always_comb begin
      mul_cmd = '0;
      case (state_ff)
         S_MUL1_GO: begin
            mul_cmd.start = 1'b1;
            mul_cmd.a     = {16'd0, mu_mag};
            mul_cmd.b     = {16'd0, cfg.inv_prior_weight};
         end
         S_MUL2_GO: begin
            mul_cmd.start = 1'b1;
            mul_cmd.a     = {59'd0, cfg.row_count};
            mul_cmd.b     = {24'd0, cfg.stream_total};
         end
         S_MUL3_GO: begin
            mul_cmd.start = 1'b1;
            mul_cmd.a     = {43'd0, wm1_mag};
            mul_cmd.b     = vrs_mag;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vrs_ff       <= '0;
         crs_ff       <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  state_ff <= S_PAIR;
               end
            end
            S_PAIR: begin
               if (card_ff == 21'd1) begin
                  err_ff   <= 1'b1;
                  state_ff <= last_ff ? S_FIN : S_IDLE;
               end else begin
                  state_ff <= S_DIVV_GO;
               end
            end
            S_DIVV_GO: state_ff <= S_DIVV_WAIT;
            S_DIVV_WAIT: begin
               if (div_rsp.done) begin
                  vrs_ff   <= sat_add(vrs_ff, r1);
                  state_ff <= S_DIVC_GO;
               end
            end
            S_DIVC_GO: state_ff <= S_DIVC_WAIT;
            S_DIVC_WAIT: begin
               if (div_rsp.done) begin
                  crs_ff   <= sat_add(crs_ff, r2);
                  state_ff <= last_ff ? S_FIN : S_IDLE;
               end
            end
            S_FIN: begin
               if (den_c == 64'd0) begin
                  rsp_valid_ff <= 1'b1;
                  vrs_ff       <= '0;
                  crs_ff       <= '0;
                  err_ff       <= 1'b0;
                  state_ff     <= S_IDLE;
               end else begin
                  state_ff <= S_MUL1_GO;
               end
            end
            S_MUL1_GO: state_ff <= S_MUL1_WAIT;
            S_MUL1_WAIT: begin
               if (mul_rsp.done) begin
                  state_ff <= S_MUL2_GO;
               end
            end
            S_MUL2_GO: state_ff <= S_MUL2_WAIT;
            S_MUL2_WAIT: begin
               if (mul_rsp.done) begin
                  state_ff <= S_MUL3_GO;
               end
            end
            S_MUL3_GO: state_ff <= S_MUL3_WAIT;
            S_MUL3_WAIT: begin
               if (mul_rsp.done) begin
                  state_ff <= S_DIVF_GO;
               end
            end
            S_DIVF_GO: state_ff <= S_DIVF_WAIT;
            S_DIVF_WAIT: begin
               if (div_rsp.done) begin
                  rsp_valid_ff <= 1'b1;
                  vrs_ff       <= '0;
                  crs_ff       <= '0;
                  err_ff       <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               vol_ff  <= req_data.counter_volume;
               card_ff <= req_data.counter_card;
               last_ff <= req_data.last_pair;
            end
         end
         S_FIN: begin
            den_ff <= den_c;
            if (den_c == 64'd0) begin
               rsp_data_ff.estimate <= '0;
               rsp_data_ff.status   <= 1'b1;
            end
         end
         S_MUL1_WAIT: begin
            if (mul_rsp.done) begin
               acc_ff <= mu_neg ? ((~t1_mag) + 128'd1) : t1_mag;
            end
         end
         S_MUL2_WAIT: begin
            if (mul_rsp.done) begin
               acc_ff <= acc_ff - (mul_rsp.product << FRAC_BITS);
            end
         end
         S_MUL3_WAIT: begin
            if (mul_rsp.done) begin
               acc_ff <= t3_neg ? (acc_ff - mul_rsp.product) : (acc_ff + mul_rsp.product);
            end
         end
         S_DIVF_GO: nneg_ff <= num[127];
         S_DIVF_WAIT: begin
            if (div_rsp.done) begin
               rsp_data_ff.estimate <= est_c;
               rsp_data_ff.status   <= err_ff;
            end
         end
         default: ;
      endcase
   end

endmodule
